// ===== src/gspc_pkg.sv =====
// ----------------------------------------------------------------------------
// gspc_pkg: shared types and constants of the gas sensor ppm converter
// Sizes, reset values, status and register codes, and the Q30 root table
// used by the power-of-two stage.
// ----------------------------------------------------------------------------
package gspc_pkg;

    localparam int WINDOW      = 5000;
    localparam int SAMPLE_BITS = 12;
    localparam int SUM_W       = 28;
    localparam int CNT_W       = 16;
    localparam int RES_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_W       = 40;
    localparam int DSR_W       = 24;
    localparam int MUL_W       = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ICPT     = 2'd2;

    localparam logic [15:0]      LOAD_RST  = 16'd2560;
    localparam logic [15:0]      SLOPE_RST = 16'hE785;
    localparam logic [15:0]      ICPT_RST  = 16'd7045;
    localparam logic [RES_W-1:0] REF_RST   = 24'd1024;
    localparam logic [RES_W-1:0] MAX24     = 24'hFFFFFF;
    localparam logic [15:0]      RES_NUM   = 16'd45500;
    localparam logic [17:0]      LOG2_TEN_Q16 = 18'd217706;
    localparam logic [MUL_W-1:0] Q30_ONE   = 31'h4000_0000;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [RES_W-1:0]       t_res;
    typedef logic [11:0]            t_mean;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_MEAN  = 2'd1,
        ST_SAT        = 2'd2,
        ST_ZERO_SLOPE = 2'd3
    } t_status;

    typedef logic [MUL_W-1:0] t_root_tab [16];

    function automatic logic [63:0] f_isqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-(k+1)) in Q30
    function automatic t_root_tab f_root_tab();
        t_root_tab tab;
        tab[0] = MUL_W'(f_isqrt(64'd2 << 60));
        for (int k = 1; k < 16; k++) begin
            tab[k] = MUL_W'(f_isqrt({33'b0, tab[k-1]} << 30));
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

    function automatic logic [15:0] f_times11(input logic [11:0] m);
        return ({4'b0, m} << 3) + ({4'b0, m} << 1) + {4'b0, m};
    endfunction

endpackage

// ===== src/gspc_in_if.sv =====
// ----------------------------------------------------------------------------
// gspc_in_if: sample channel
// Valid/ready channel carrying one converter code and the calibrate flag.
// ----------------------------------------------------------------------------
interface gspc_in_if;
    import gspc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    calibrate;

    modport source (output valid, output sample, output calibrate, input ready);
    modport sink   (input valid, input sample, input calibrate, output ready);
endinterface

// ===== src/gspc_out_if.sv =====
// ----------------------------------------------------------------------------
// gspc_out_if: result channel
// Valid/ready channel carrying one per-window conversion result.
// ----------------------------------------------------------------------------
interface gspc_out_if;
    import gspc_pkg::*;

    logic    valid;
    logic    ready;
    t_mean   mean_code;
    t_res    sensor_res;
    t_res    res_ratio;
    t_res    gas_ppm;
    logic    calibrated;
    t_status status;

    modport source (output valid, output mean_code, output sensor_res, output res_ratio,
                    output gas_ppm, output calibrated, output status, input ready);
    modport sink   (input valid, input mean_code, input sensor_res, input res_ratio,
                    input gas_ppm, input calibrated, input status, output ready);
endinterface

// ===== src/gas_sensor_ppm_converter_core.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_core: windowed gas sensor ppm converter
// Sample items enter on i_sample_ch; every WINDOW-th item produces one result
// item on o_result_ch (mean code, resistance, ratio, ppm, calibrated, status).
// Registers load_resistance, curve_slope, curve_intercept are written through
// i_cfg_we / i_cfg_idx / i_cfg_data. The user must write them only while the
// block is idle; the block itself does not enforce it. Throughput: one sample
// item per cycle inside a window, as long as no finished result waits for
// the output register. The last item of a window starts a sequencer that runs
// a bit-serial divider (four passes) and a bit-serial multiplier (one pass for
// resistance, sixteen squarings for log2, one for the intercept term and up
// to sixteen for 2^x), plus a normalize and a shift, and takes no sample.
// The result sits in an output register; the next window is accumulated
// while it waits. If it is still not taken when the next result is ready,
// the sequencer holds and sample intake stops.
// Reset (synchronous, active low) clears the window, sets the reference to
// 4.0 kilo-ohm and the registers to their defaults; no result is pending.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gspc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gspc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    gspc_in_if.sink                             i_sample_ch,
    gspc_out_if.source                          o_result_ch
);
    import gspc_pkg::*;

    typedef enum logic [12:0] {
        S_ACC       = 13'b0000000000001,
        S_MEAN      = 13'b0000000000010,
        S_RES_MUL   = 13'b0000000000100,
        S_RES_DIV   = 13'b0000000001000,
        S_RAT_DIV   = 13'b0000000010000,
        S_CHECK     = 13'b0000000100000,
        S_LOG_NORM  = 13'b0000001000000,
        S_LOG_SQ    = 13'b0000010000000,
        S_IC_MUL    = 13'b0000100000000,
        S_T_DIV     = 13'b0001000000000,
        S_POW_SEL   = 13'b0010000000000,
        S_POW_MUL   = 13'b0100000000000,
        S_POW_SHIFT = 13'b1000000000000
    } t_state_base;

    typedef t_state_base t_state;

    localparam logic [5:0] LAST_DIV = 6'(DIV_W - 1);
    localparam logic [5:0] LAST_MUL = 6'(MUL_W - 1);
    localparam logic signed [41:0] T_BIAS = 42'sd524288;
    localparam logic signed [41:0] T_SAT  = 42'sd1572864;

    t_state              r_state;
    logic                r_done;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [RES_W-1:0]    r_ref;
    logic [15:0]         r_load;
    logic [15:0]         r_slope;
    logic [15:0]         r_icpt;
    logic                r_out_valid;
    logic [5:0]          r_cnt;
    logic [4:0]          r_k;

    logic [DIV_W-1:0]    r_quo;
    logic [DSR_W:0]      r_rem;
    logic [DSR_W-1:0]    r_dsr;
    logic [MUL_W-1:0]    r_mul_a;
    logic [2*MUL_W-1:0]  r_prod;

    t_mean               r_mean;
    t_res                r_res;
    t_res                r_ratio;
    t_res                r_ppm;
    logic                r_sat;
    logic                r_cal;
    logic                r_cal_req;
    logic                r_zero;
    logic [MUL_W-1:0]    r_x;
    logic [4:0]          r_p;
    logic [15:0]         r_frac;
    logic                r_neg;
    logic [4:0]          r_ip;
    logic [15:0]         r_f;
    logic [MUL_W-1:0]    r_m;

    t_mean               r_o_mean;
    t_res                r_o_res;
    t_res                r_o_ratio;
    t_res                r_o_ppm;
    logic                r_o_cal;
    t_status             r_o_status;

    logic                in_fire;
    logic                last_smp;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;

    logic [DSR_W:0]      rem_sh;
    logic [DSR_W+1:0]    rem_dif;
    logic                div_ge;
    logic [DSR_W:0]      div_rem_n;
    logic [DIV_W-1:0]    div_quo_n;

    logic [MUL_W:0]      mul_add;
    logic [2*MUL_W-1:0]  mul_prod_n;

    t_mean               mean_clip;
    t_res                res_clip;
    t_res                ref_use;
    t_res                ratio_clip;
    logic [31:0]         sq;
    logic [MUL_W-1:0]    sq_x;
    logic [16:0]         icpt_mag;
    logic [16:0]         slope_mag;
    logic [20:0]         ic_mag;
    logic signed [23:0]  log_val;
    logic signed [23:0]  ic_val;
    logic signed [23:0]  num_val;
    logic [23:0]         num_mag;
    logic signed [41:0]  t_val;

    assign in_fire  = i_sample_ch.valid && i_sample_ch.ready;
    assign last_smp = in_fire && (r_count == CNT_W'(WINDOW - 1));
    assign sum_add  = {1'b0, r_sum} + (SUM_W+1)'(i_sample_ch.sample);
    assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    // restoring divider step
    assign rem_sh    = {r_rem[DSR_W-1:0], r_quo[DIV_W-1]};
    assign rem_dif   = {1'b0, rem_sh} - {2'b0, r_dsr};
    assign div_ge    = !rem_dif[DSR_W+1];
    assign div_rem_n = div_ge ? rem_dif[DSR_W:0] : rem_sh;
    assign div_quo_n = {r_quo[DIV_W-2:0], div_ge};

    // shift-add multiplier step, multiplier in the low half
    assign mul_add    = {1'b0, r_prod[2*MUL_W-1:MUL_W]} + {1'b0, (r_prod[0] ? r_mul_a : '0)};
    assign mul_prod_n = {mul_add, r_prod[MUL_W-1:1]};

    assign mean_clip  = (|div_quo_n[DIV_W-1:12]) ? 12'hFFF : div_quo_n[11:0];
    assign res_clip   = (|div_quo_n[DIV_W-1:RES_W]) ? MAX24 : div_quo_n[RES_W-1:0];
    assign ratio_clip = res_clip;
    assign ref_use    = r_cal_req ? res_clip : r_ref;

    assign sq   = mul_prod_n[61:30];
    assign sq_x = sq[31] ? sq[31:1] : sq[30:0];

    assign icpt_mag  = r_icpt[15] ? (17'd0 - {1'b1, r_icpt}) : {1'b0, r_icpt};
    assign slope_mag = r_slope[15] ? (17'd0 - {1'b1, r_slope}) : {1'b0, r_slope};
    assign ic_mag    = mul_prod_n[32:12];
    assign log_val   = $signed({8'({3'b0, r_p}) - 8'd16, r_frac});
    assign ic_val    = r_icpt[15] ? -$signed({3'b0, ic_mag}) : $signed({3'b0, ic_mag});
    assign num_val   = log_val - ic_val;
    assign num_mag   = num_val[23] ? 24'(-num_val) : num_val;
    assign t_val     = r_neg ? (T_BIAS - $signed({2'b0, div_quo_n}))
                             : (T_BIAS + $signed({2'b0, div_quo_n}));

    assign i_sample_ch.ready     = (r_state == S_ACC) && !r_done;
    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.mean_code = r_o_mean;
    assign o_result_ch.sensor_res = r_o_res;
    assign o_result_ch.res_ratio = r_o_ratio;
    assign o_result_ch.gas_ppm   = r_o_ppm;
    assign o_result_ch.calibrated = r_o_cal;
    assign o_result_ch.status    = r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_done      <= 1'b0;
            r_sum       <= '0;
            r_count     <= '0;
            r_ref       <= REF_RST;
            r_load      <= LOAD_RST;
            r_slope     <= SLOPE_RST;
            r_icpt      <= ICPT_RST;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LOAD_RES: r_load  <= i_cfg_data;
                    CFG_SLOPE:    r_slope <= i_cfg_data;
                    CFG_ICPT:     r_icpt  <= i_cfg_data;
                    default: ;
                endcase
            end

            // finished result waits here for the output register
            if (r_done && (!r_out_valid || o_result_ch.ready)) begin
                r_done      <= 1'b0;
                r_out_valid <= 1'b1;
                r_o_mean    <= r_mean;
                r_o_res     <= r_res;
                r_o_ratio   <= r_ratio;
                r_o_ppm     <= r_ppm;
                r_o_cal     <= r_cal;
                r_o_status  <= r_zero ? ST_ZERO_MEAN :
                               (r_slope == 16'd0) ? ST_ZERO_SLOPE :
                               r_sat ? ST_SAT : ST_OK;
            end else if (o_result_ch.valid && o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_ACC: begin
                    if (in_fire) begin
                        r_count <= r_count + 16'd1;
                        r_sum   <= sum_sat;
                        if (last_smp) begin
                            r_count   <= '0;
                            r_sum     <= '0;
                            r_quo     <= DIV_W'(sum_sat);
                            r_rem     <= '0;
                            r_dsr     <= DSR_W'(WINDOW);
                            r_cnt     <= '0;
                            r_cal_req <= i_sample_ch.calibrate;
                            r_sat     <= 1'b0;
                            r_cal     <= 1'b0;
                            r_zero    <= 1'b0;
                            r_res     <= '0;
                            r_ratio   <= '0;
                            r_ppm     <= '0;
                            r_state   <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    r_rem <= div_rem_n;
                    r_quo <= div_quo_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_DIV) begin
                        r_cnt <= '0;
                        if (div_quo_n == '0) begin
                            r_mean  <= '0;
                            r_zero  <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= S_ACC;
                        end else begin
                            r_mean  <= mean_clip;
                            r_mul_a <= MUL_W'(r_load);
                            r_prod  <= {31'b0, MUL_W'(RES_NUM - f_times11(mean_clip))};
                            r_state <= S_RES_MUL;
                        end
                    end
                end
                S_RES_MUL: begin
                    r_prod <= mul_prod_n;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == LAST_MUL) begin
                        r_cnt   <= '0;
                        r_quo   <= DIV_W'(mul_prod_n[31:0]);
                        r_rem   <= '0;
                        r_dsr   <= DSR_W'(f_times11(r_mean));
                        r_state <= S_RES_DIV;
                    end
                end
                S_RES_DIV: begin
                    r_rem <= div_rem_n;
                    r_quo <= div_quo_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_DIV) begin
                        r_cnt <= '0;
                        r_res <= res_clip;
                        if (|div_quo_n[DIV_W-1:RES_W]) begin
                            r_sat <= 1'b1;
                        end
                        if (r_cal_req) begin
                            r_ref <= res_clip;
                            r_cal <= 1'b1;
                        end
                        if (ref_use == '0) begin
                            r_ratio <= MAX24;
                            r_sat   <= 1'b1;
                            r_state <= S_CHECK;
                        end else begin
                            r_quo   <= {res_clip, 16'b0};
                            r_rem   <= '0;
                            r_dsr   <= ref_use;
                            r_state <= S_RAT_DIV;
                        end
                    end
                end
                S_RAT_DIV: begin
                    r_rem <= div_rem_n;
                    r_quo <= div_quo_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_DIV) begin
                        r_cnt   <= '0;
                        r_ratio <= ratio_clip;
                        if (|div_quo_n[DIV_W-1:RES_W]) begin
                            r_sat <= 1'b1;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_slope == 16'd0) begin
                        r_done  <= 1'b1;
                        r_state <= S_ACC;
                    end else if (r_ratio == '0) begin
                        if (r_slope[15]) begin
                            r_ppm <= MAX24;
                            r_sat <= 1'b1;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_ACC;
                    end else begin
                        r_x     <= {r_ratio, 7'b0};
                        r_p     <= 5'd23;
                        r_state <= S_LOG_NORM;
                    end
                end
                S_LOG_NORM: begin
                    if (r_x[MUL_W-1]) begin
                        r_mul_a <= r_x;
                        r_prod  <= {31'b0, r_x};
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_frac  <= '0;
                        r_state <= S_LOG_SQ;
                    end else begin
                        r_x <= {r_x[MUL_W-2:0], 1'b0};
                        r_p <= r_p - 5'd1;
                    end
                end
                S_LOG_SQ: begin
                    r_prod <= mul_prod_n;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == LAST_MUL) begin
                        r_cnt  <= '0;
                        r_frac <= {r_frac[14:0], sq[31]};
                        r_x    <= sq_x;
                        r_k    <= r_k + 5'd1;
                        if (r_k == 5'd15) begin
                            r_mul_a <= MUL_W'(icpt_mag);
                            r_prod  <= {31'b0, MUL_W'(LOG2_TEN_Q16)};
                            r_state <= S_IC_MUL;
                        end else begin
                            r_mul_a <= sq_x;
                            r_prod  <= {31'b0, sq_x};
                        end
                    end
                end
                S_IC_MUL: begin
                    r_prod <= mul_prod_n;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == LAST_MUL) begin
                        r_cnt   <= '0;
                        r_quo   <= DIV_W'({num_mag, 12'b0});
                        r_rem   <= '0;
                        r_dsr   <= DSR_W'(slope_mag);
                        r_neg   <= num_val[23] ^ r_slope[15];
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    r_rem <= div_rem_n;
                    r_quo <= div_quo_n;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == LAST_DIV) begin
                        r_cnt <= '0;
                        priority if (t_val >= T_SAT) begin
                            r_ppm   <= MAX24;
                            r_sat   <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= S_ACC;
                        end else if (t_val < 0) begin
                            r_done  <= 1'b1;
                            r_state <= S_ACC;
                        end else begin
                            r_ip    <= t_val[20:16];
                            r_f     <= t_val[15:0];
                            r_m     <= Q30_ONE;
                            r_k     <= '0;
                            r_state <= S_POW_SEL;
                        end
                    end
                end
                S_POW_SEL: begin
                    priority if (r_k[4]) begin
                        r_cnt   <= {1'b0, 5'd30 - r_ip};
                        r_state <= S_POW_SHIFT;
                    end else if (r_f[15]) begin
                        r_mul_a <= r_m;
                        r_prod  <= {31'b0, ROOT_TAB[r_k[3:0]]};
                        r_cnt   <= '0;
                        r_state <= S_POW_MUL;
                    end else begin
                        r_k <= r_k + 5'd1;
                        r_f <= {r_f[14:0], 1'b0};
                    end
                end
                S_POW_MUL: begin
                    r_prod <= mul_prod_n;
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == LAST_MUL) begin
                        r_cnt   <= '0;
                        r_m     <= mul_prod_n[60:30];
                        r_k     <= r_k + 5'd1;
                        r_f     <= {r_f[14:0], 1'b0};
                        r_state <= S_POW_SEL;
                    end
                end
                S_POW_SHIFT: begin
                    if (r_cnt == '0) begin
                        r_ppm   <= r_m[RES_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= S_ACC;
                    end else begin
                        r_m   <= {1'b0, r_m[MUL_W-1:1]};
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                default: r_state <= S_ACC;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(WINDOW))
        else $error("window count reached window length");

    a_window_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_smp |=> (r_state == S_MEAN) && (r_count == '0))
        else $error("last sample of window did not start conversion");

    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_status == ST_ZERO_MEAN)) |->
        (r_o_res == '0) && (r_o_ppm == '0) && !r_o_cal)
        else $error("zero mean result carries nonzero fields");

    a_zero_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_status == ST_ZERO_SLOPE)) |-> (r_o_ppm == '0))
        else $error("zero slope result carries nonzero ppm");
`endif

endmodule
